>>> sv/mgpvu_pkg.sv
// Shared constants, types and field widths for the MAC-grid velocity update block.
package mgpvu_pkg;
	localparam int unsigned DefMaxWidth  = 256;
	localparam int unsigned DefMaxHeight = 256;
	localparam int unsigned DefMaxDepth  = 256;
	localparam int unsigned DimW  = 9;
	localparam int unsigned DataW = 32;
	localparam int unsigned IdxW  = 2;

	localparam logic [IdxW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IdxW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IdxW-1:0] REG_DEPTH  = 2'd2;
	localparam logic [IdxW-1:0] REG_THREE_D = 2'd3;

	// class bits: bit0 fluid, bit1 empty
	typedef logic [1:0] cls_t;

	// classified cell handed from front to back
	typedef struct packed {
		logic                    border;
		logic                    fl;
		logic                    em;
		logic                    td;
		logic signed [DataW-1:0] p;
		logic signed [DataW-1:0] vx;
		logic signed [DataW-1:0] vy;
		logic signed [DataW-1:0] vz;
		cls_t                    ncls_x;
		cls_t                    ncls_y;
		cls_t                    ncls_z;
		logic signed [DataW-1:0] pn_x;
		logic signed [DataW-1:0] pn_y;
		logic signed [DataW-1:0] pn_z;
	} cell_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
		logic signed [DataW+1:0] hi;
		logic signed [DataW+1:0] lo;
		hi = (DataW+2)'(signed'({1'b0, {(DataW-1){1'b1}}}));
		lo = -hi - (DataW+2)'(1);
		if (v > hi) return hi[DataW-1:0];
		if (v < lo) return lo[DataW-1:0];
		return v[DataW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] axis(input logic fl,
			input logic signed [DataW-1:0] v, input logic signed [DataW-1:0] p,
			input cls_t nc, input logic signed [DataW-1:0] pn);
		logic signed [DataW+1:0] r;
		r = (DataW+2)'(v);
		if (fl) begin
			if (nc[0]) r = r - (DataW+2)'(p) + (DataW+2)'(pn);
			if (nc[1]) r = r - (DataW+2)'(p);
		end else begin
			r = nc[0] ? (DataW+2)'(v) + (DataW+2)'(pn) : '0;
		end
		return sat32(r);
	endfunction
endpackage

>>> sv/mgpvu_front.sv
// Front end: grid position, neighbour stores and cell classification.
module mgpvu_front #(
	parameter int unsigned MAX_WIDTH  = mgpvu_pkg::DefMaxWidth,
	parameter int unsigned MAX_HEIGHT = mgpvu_pkg::DefMaxHeight,
	parameter int unsigned MAX_DEPTH  = mgpvu_pkg::DefMaxDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [mgpvu_pkg::DimW-1:0] grid_width,
	input  logic [mgpvu_pkg::DimW-1:0] grid_height,
	input  logic [mgpvu_pkg::DimW-1:0] grid_depth,
	input  logic                  three_d,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  is_fluid,
	input  logic                  is_empty,
	input  logic                  is_outflow,
	input  logic [mgpvu_pkg::DataW-1:0] pressure,
	input  logic [mgpvu_pkg::DataW-1:0] velocity_x,
	input  logic [mgpvu_pkg::DataW-1:0] velocity_y,
	input  logic [mgpvu_pkg::DataW-1:0] velocity_z,
	output logic                  cell_valid,
	input  logic                  cell_ready,
	output mgpvu_pkg::cell_t      item
);
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned ZW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int unsigned PW = XW + YW;
	localparam int unsigned PD = 1 << PW;
	localparam int unsigned CW = 13; // position counters, wide enough for 4096
	localparam int unsigned SW = mgpvu_pkg::DataW + 2;

	logic [CW-1:0] x_q, y_q, z_q;
	logic [CW-1:0] w, h, d;

	// clamp dimension registers into 1..MAX
	always_comb begin
		w = CW'(grid_width);  h = CW'(grid_height); d = CW'(grid_depth);
		if (w == '0) w = CW'(1);
		if (h == '0) h = CW'(1);
		if (d == '0) d = CW'(1);
		if (w > CW'(MAX_WIDTH))  w = CW'(MAX_WIDTH);
		if (h > CW'(MAX_HEIGHT)) h = CW'(MAX_HEIGHT);
		if (d > CW'(MAX_DEPTH))  d = CW'(MAX_DEPTH);
	end

	logic [XW-1:0] xi;
	logic [PW-1:0] pi;
	assign xi = x_q[XW-1:0];
	assign pi = PW'({y_q[YW-1:0], xi});

	// stage 1 holds the item while the stores are read
	logic s1_q;
	logic stall;
	logic [SW-1:0] info_s1;
	logic border_s1, fl_s1, em_s1, td_s1;
	logic signed [mgpvu_pkg::DataW-1:0] p_s1, vx_s1, vy_s1, vz_s1, lp_q;
	mgpvu_pkg::cls_t lc_q, rc_s1, pc_s1;
	logic signed [mgpvu_pkg::DataW-1:0] rp_s1, pp_s1;
	logic signed [mgpvu_pkg::DataW-1:0] lp_s1;
	mgpvu_pkg::cls_t lc_s1;

	logic [mgpvu_pkg::DataW-1:0] row_p_mem [MAX_WIDTH];
	mgpvu_pkg::cls_t            row_c_mem [MAX_WIDTH];
	logic [mgpvu_pkg::DataW-1:0] pl_p_mem [PD];
	mgpvu_pkg::cls_t            pl_c_mem [PD];

	assign stall = s1_q && !cell_ready;
	assign in_ready = !stall;
	assign cell_valid = s1_q;

	logic take;
	logic border;
	assign take = in_valid && in_ready;
	always_comb begin
		border = (x_q < CW'(1)) || (x_q + CW'(2) > w) || (y_q < CW'(1)) ||
			(y_q + CW'(2) > h);
		if (three_d && ((z_q < CW'(1)) || (z_q + CW'(2) > d))) border = 1'b1;
	end

	// read-before-write: a cell reads the entry the previous row/plane left
	always_ff @(posedge clk) begin
		if (take) begin
			rp_s1 <= row_p_mem[xi];
			rc_s1 <= row_c_mem[xi];
			pp_s1 <= pl_p_mem[pi];
			pc_s1 <= pl_c_mem[pi];
			row_p_mem[xi] <= pressure;
			row_c_mem[xi] <= {is_empty, is_fluid};
			pl_p_mem[pi] <= pressure;
			pl_c_mem[pi] <= {is_empty, is_fluid};
			lp_s1 <= lp_q;
			lc_s1 <= lc_q;
			lp_q <= pressure;
			lc_q <= {is_empty, is_fluid};
			p_s1 <= pressure;
			vx_s1 <= velocity_x;
			vy_s1 <= velocity_y;
			vz_s1 <= three_d ? velocity_z : '0;
			border_s1 <= border;
			fl_s1 <= is_fluid;
			em_s1 <= is_empty && !is_outflow;
			td_s1 <= three_d;
			info_s1 <= '0;
		end
	end

	// advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; z_q <= '0; s1_q <= 1'b0;
		end else begin
			if (!stall) s1_q <= in_valid;
			if (take) begin
				if (x_q + CW'(1) >= w) begin
					x_q <= '0;
					if (y_q + CW'(1) >= h) begin
						y_q <= '0;
						z_q <= (z_q + CW'(1) >= d) ? '0 : z_q + CW'(1);
					end else y_q <= y_q + CW'(1);
				end else x_q <= x_q + CW'(1);
			end
		end
	end

	always_comb begin
		item.border = border_s1 | (|info_s1);
		item.fl = fl_s1; item.em = em_s1; item.td = td_s1;
		item.p = p_s1; item.vx = vx_s1; item.vy = vy_s1; item.vz = vz_s1;
		item.ncls_x = lc_s1; item.pn_x = lp_s1;
		item.ncls_y = rc_s1; item.pn_y = rp_s1;
		item.ncls_z = pc_s1; item.pn_z = pp_s1;
	end

	logic unused_zw;
	assign unused_zw = ^ZW;
endmodule

>>> sv/mgpvu_fifo.sv
// Two-entry queue between front and back.
module mgpvu_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  mgpvu_pkg::cell_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output mgpvu_pkg::cell_t rd_data
);
	mgpvu_pkg::cell_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

>>> sv/mgpvu_back.sv
// Back end: per-axis correction arithmetic and the output register.
module mgpvu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cell_valid,
	output logic             cell_ready,
	input  mgpvu_pkg::cell_t item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3*mgpvu_pkg::DataW-1:0] out_data
);
	logic signed [mgpvu_pkg::DataW-1:0] ox, oy, oz;
	logic valid_q;

	always_comb begin
		ox = item.vx; oy = item.vy; oz = item.vz;
		if (!item.border && (item.fl || item.em)) begin
			ox = mgpvu_pkg::axis(item.fl, item.vx, item.p, item.ncls_x, item.pn_x);
			oy = mgpvu_pkg::axis(item.fl, item.vy, item.p, item.ncls_y, item.pn_y);
			if (item.td)
				oz = mgpvu_pkg::axis(item.fl, item.vz, item.p, item.ncls_z, item.pn_z);
		end
		if (!item.td) oz = '0;
	end

	assign cell_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk) begin
		if (cell_valid && cell_ready) out_data <= {oz, oy, ox};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cell_ready) valid_q <= cell_valid;
	end
endmodule

>>> sv/mac_grid_pressure_velocity_update.sv
// Top level of the MAC-grid pressure projection velocity correction.
// Cells stream in raster order (x fastest, then y, then z), one word per cell, and
// one corrected-velocity word leaves per cell, in order. Sustained rate is one cell
// per cycle while m_axis_tready is high, through the store read stage, queue and
// output register. Row and plane memories are read before written in the same cycle,
// giving each cell its -y and -z neighbours; a register gives its -x one. Border
// cells pass through; z is ignored unless three_d is set. No clearing pass is run.
module mac_grid_pressure_velocity_update #(
	parameter int unsigned MAX_WIDTH  = mgpvu_pkg::DefMaxWidth,
	parameter int unsigned MAX_HEIGHT = mgpvu_pkg::DefMaxHeight,
	parameter int unsigned MAX_DEPTH  = mgpvu_pkg::DefMaxDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [mgpvu_pkg::IdxW-1:0] cfg_index,
	input  logic [mgpvu_pkg::DimW-1:0] cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: is_fluid, is_empty, is_outflow, pressure, velocity_x, velocity_y,
	// velocity_z (lowest first), zero filled to 136 bits
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: new_velocity_x, new_velocity_y, new_velocity_z (lowest first)
	output logic [95:0]  m_axis_tdata
);
	logic [mgpvu_pkg::DimW-1:0] width_q, height_q, depth_q;
	logic three_d_q;

	// hold configuration; written only while idle by the user, not enforced by the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256; height_q <= 9'd256; depth_q <= 9'd1; three_d_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mgpvu_pkg::REG_WIDTH:   width_q <= cfg_data;
				mgpvu_pkg::REG_HEIGHT:  height_q <= cfg_data;
				mgpvu_pkg::REG_DEPTH:   depth_q <= cfg_data;
				mgpvu_pkg::REG_THREE_D: three_d_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, b_valid, b_ready;
	mgpvu_pkg::cell_t f_cell, b_cell;

	mgpvu_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
			.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk, .arst_n,
		.grid_width(width_q), .grid_height(height_q), .grid_depth(depth_q),
		.three_d(three_d_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.is_fluid(s_axis_tdata[0]), .is_empty(s_axis_tdata[1]),
		.is_outflow(s_axis_tdata[2]), .pressure(s_axis_tdata[34:3]),
		.velocity_x(s_axis_tdata[66:35]), .velocity_y(s_axis_tdata[98:67]),
		.velocity_z(s_axis_tdata[130:99]),
		.cell_valid(f_valid), .cell_ready(f_ready), .item(f_cell)
	);

	mgpvu_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cell),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cell)
	);

	mgpvu_back u_back (
		.clk, .arst_n,
		.cell_valid(b_valid), .cell_ready(b_ready), .item(b_cell),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[135:131];
endmodule
